/* hw/rtl/osg_pkg.sv */
package osg_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int MAX_RESULTS  = 64;
  localparam int ID_W         = 32;
  localparam int OP_W         = 3;
  localparam int WAVE_W       = 6;
  localparam int GS_W         = 7;
  localparam int CNT_OUT_W    = 7;
  localparam int PROD_W       = WAVE_W + GS_W;
  localparam logic [GS_W-1:0] GS_RESET = 7'd1;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY  = 3'd0,
    OP_TOGGLE = 3'd1,
    OP_ADD    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_KEEP   = 3'd4,
    OP_FINISH = 3'd5,
    OP_WAVE   = 3'd6
  } op_t;

  typedef struct packed {
    logic            mark;
    logic [ID_W-1:0] id;
  } entry_t;

endpackage

/* hw/rtl/osg_mem.sv */
module osg_mem #(
  parameter int DEPTH = osg_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  osg_pkg::entry_t  wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output osg_pkg::entry_t  rdata
);

  osg_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/osg_div.sv */
// Restoring divider, one quotient bit per cycle.
module osg_div #(
  parameter int NUM_W = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [NUM_W-1:0]         num,
  input  logic [osg_pkg::GS_W-1:0] den,
  output logic                     done,
  output logic [NUM_W-1:0]         quo
);

  localparam int CW = $clog2(NUM_W + 1);
  localparam int DW = osg_pkg::GS_W;

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic          done_r;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= num;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* hw/rtl/ordered_id_set_with_groups.sv */
// Query/toggle/add/remove/keep scan one entry per cycle until a hit; a toggle or remove hit
// then shifts the later entries down, and finish compacts the kept ones. Every op then runs
// group-count division (NUM_W = clog2(CAPACITY+127), 8 at CAPACITY 64); all but a wave read
// give one result strobe; a wave read gives one id per cycle, back to back (or one out_none).
// One item at a time. Synchronous reset empties the set, goes idle and sets group_size to 1;
// id/mark memory is not cleared, entries are written before read. Results cannot be stalled.
module ordered_id_set_with_groups #(
  parameter int CAPACITY = osg_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [osg_pkg::OP_W-1:0]      in_op,
  input  logic [osg_pkg::ID_W-1:0]      in_ship_id,
  input  logic [osg_pkg::WAVE_W-1:0]    in_wave_index,
  output logic                          out_strobe,
  output logic                          out_present,
  output logic [osg_pkg::ID_W-1:0]      out_id,
  output logic                          out_last,
  output logic                          out_none,
  output logic                          out_status,
  output logic [osg_pkg::CNT_OUT_W-1:0] out_held_count,
  output logic [osg_pkg::CNT_OUT_W-1:0] out_group_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [osg_pkg::GS_W-1:0]      cfg_group_size
);

  localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int NUM_W  = $clog2(CAPACITY + (1 << osg_pkg::GS_W) - 1);
  localparam int PROD_W = osg_pkg::PROD_W;
  localparam int CW     = (CNT_W > PROD_W) ? CNT_W : PROD_W;
  localparam int GS_W   = osg_pkg::GS_W;
  localparam int OCW    = osg_pkg::CNT_OUT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_COMPACT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_WAVE_SET,
    S_WAVE
  } state_t;

  state_t                     state_r, state_nxt;
  osg_pkg::op_t               op_r, op_nxt;
  logic [osg_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [osg_pkg::WAVE_W-1:0] wave_r, wave_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [GS_W-1:0]            gs_r, gs_nxt;
  logic [OCW-1:0]             gc_r, gc_nxt;
  logic [CNT_W-1:0]           scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0]           scan_end_r, scan_end_nxt;
  logic [CNT_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic                       data_vld_r, data_vld_nxt;
  logic [CNT_W-1:0]           data_idx_r, data_idx_nxt;
  logic                       present_r, present_nxt;
  logic                       status_r, status_nxt;
  logic [PROD_W-1:0]          prod_r, prod_nxt;

  logic                       out_strobe_r, out_strobe_nxt;
  logic                       out_present_r, out_present_nxt;
  logic [osg_pkg::ID_W-1:0]   out_id_r, out_id_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_none_r, out_none_nxt;
  logic                       out_status_r, out_status_nxt;

  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  osg_pkg::entry_t            mem_wdata, mem_rdata;

  logic                       div_start, div_done;
  logic [NUM_W-1:0]           div_num, div_quo;

  logic                       scan_more, scan_over, hit;
  logic [CW-1:0]              n_w;

  osg_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  osg_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (gs_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign scan_more = scan_ptr_r < scan_end_r;
  assign scan_over = !scan_more && !data_vld_r;
  assign hit       = data_vld_r && (mem_rdata.id == id_r);
  assign mem_raddr = scan_ptr_r[AW-1:0];
  assign div_num   = NUM_W'(count_r) + NUM_W'(gs_r) - NUM_W'(1);

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    id_nxt          = id_r;
    wave_nxt        = wave_r;
    count_nxt       = count_r;
    gs_nxt          = gs_r;
    gc_nxt          = gc_r;
    scan_ptr_nxt    = scan_ptr_r;
    scan_end_nxt    = scan_end_r;
    wr_ptr_nxt      = wr_ptr_r;
    data_vld_nxt    = 1'b0;
    data_idx_nxt    = scan_ptr_r;
    present_nxt     = present_r;
    status_nxt      = status_r;
    prod_nxt        = prod_r;
    out_strobe_nxt  = 1'b0;
    out_present_nxt = out_present_r;
    out_id_nxt      = out_id_r;
    out_last_nxt    = out_last_r;
    out_none_nxt    = out_none_r;
    out_status_nxt  = out_status_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '{mark: 1'b0, id: id_r};
    mem_re          = 1'b0;
    div_start       = 1'b0;
    n_w             = '0;

    if (cfg_valid && cfg_ready) begin
      gs_nxt = cfg_group_size;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt       = osg_pkg::op_t'(in_op);
          id_nxt       = in_ship_id;
          wave_nxt     = in_wave_index;
          present_nxt  = 1'b0;
          status_nxt   = 1'b0;
          scan_ptr_nxt = '0;
          scan_end_nxt = count_r;
          wr_ptr_nxt   = '0;
          case (osg_pkg::op_t'(in_op))
            osg_pkg::OP_QUERY, osg_pkg::OP_TOGGLE, osg_pkg::OP_ADD,
            osg_pkg::OP_REMOVE, osg_pkg::OP_KEEP: state_nxt = S_SEARCH;
            osg_pkg::OP_FINISH:                  state_nxt = S_COMPACT;
            default:                             state_nxt = S_DIV_GO;
          endcase
        end
      end

      S_SEARCH: begin
        if (hit) begin
          case (op_r)
            osg_pkg::OP_TOGGLE, osg_pkg::OP_REMOVE: begin
              // close the gap: shift later entries down by one
              scan_ptr_nxt = data_idx_r + CNT_W'(1);
              scan_end_nxt = count_r;
              present_nxt  = 1'b0;
              state_nxt    = S_SHIFT;
            end
            osg_pkg::OP_KEEP: begin
              mem_we      = 1'b1;
              mem_waddr   = data_idx_r[AW-1:0];
              mem_wdata   = '{mark: 1'b1, id: id_r};
              present_nxt = 1'b1;
              state_nxt   = S_DIV_GO;
            end
            default: begin
              present_nxt = 1'b1;
              state_nxt   = S_DIV_GO;
            end
          endcase
        end else if (scan_over) begin
          if (op_r == osg_pkg::OP_TOGGLE || op_r == osg_pkg::OP_ADD) begin
            if (count_r >= CNT_W'(CAPACITY)) begin
              status_nxt = 1'b1;
            end else begin
              mem_we      = 1'b1;
              mem_waddr   = count_r[AW-1:0];
              mem_wdata   = '{mark: 1'b0, id: id_r};
              count_nxt   = count_r + CNT_W'(1);
              present_nxt = 1'b1;
            end
          end
          state_nxt = S_DIV_GO;
        end else if (scan_more) begin
          mem_re       = 1'b1;
          scan_ptr_nxt = scan_ptr_r + CNT_W'(1);
          data_vld_nxt = 1'b1;
        end
      end

      S_SHIFT: begin
        if (data_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = data_idx_r[AW-1:0] - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (scan_over) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DIV_GO;
        end else if (scan_more) begin
          mem_re       = 1'b1;
          scan_ptr_nxt = scan_ptr_r + CNT_W'(1);
          data_vld_nxt = 1'b1;
        end
      end

      S_COMPACT: begin
        // kept entries move down in order with their marks cleared
        if (data_vld_r && mem_rdata.mark) begin
          mem_we     = 1'b1;
          mem_waddr  = wr_ptr_r[AW-1:0];
          mem_wdata  = '{mark: 1'b0, id: mem_rdata.id};
          wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
        end
        if (scan_over) begin
          count_nxt = wr_ptr_r;
          state_nxt = S_DIV_GO;
        end else if (scan_more) begin
          mem_re       = 1'b1;
          scan_ptr_nxt = scan_ptr_r + CNT_W'(1);
          data_vld_nxt = 1'b1;
        end
      end

      S_DIV_GO: begin
        div_start = 1'b1;
        prod_nxt  = PROD_W'(wave_r) * PROD_W'(gs_r);
        state_nxt = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          gc_nxt = (gs_r == '0) ? '0 : div_quo[OCW-1:0];
          if (op_r == osg_pkg::OP_WAVE) begin
            state_nxt = S_WAVE_SET;
          end else begin
            out_strobe_nxt  = 1'b1;
            out_present_nxt = present_r;
            out_id_nxt      = '0;
            out_last_nxt    = 1'b1;
            out_none_nxt    = 1'b0;
            out_status_nxt  = status_r;
            state_nxt       = S_IDLE;
          end
        end
      end

      S_WAVE_SET: begin
        n_w = CW'(count_r) - CW'(prod_r);
        if (CW'(gs_r) < n_w) begin
          n_w = CW'(gs_r);
        end
        if (n_w > CW'(osg_pkg::MAX_RESULTS)) begin
          n_w = CW'(osg_pkg::MAX_RESULTS);
        end
        if (gs_r == '0 || count_r == '0 || CW'(prod_r) >= CW'(count_r)) begin
          out_strobe_nxt  = 1'b1;
          out_present_nxt = 1'b0;
          out_id_nxt      = '0;
          out_last_nxt    = 1'b1;
          out_none_nxt    = 1'b1;
          out_status_nxt  = 1'b0;
          state_nxt       = S_IDLE;
        end else begin
          scan_ptr_nxt = CNT_W'(prod_r);
          scan_end_nxt = CNT_W'(CW'(prod_r) + n_w);
          state_nxt    = S_WAVE;
        end
      end

      S_WAVE: begin
        if (data_vld_r) begin
          out_strobe_nxt  = 1'b1;
          out_present_nxt = 1'b0;
          out_id_nxt      = mem_rdata.id;
          out_last_nxt    = (data_idx_r + CNT_W'(1)) == scan_end_r;
          out_none_nxt    = 1'b0;
          out_status_nxt  = 1'b0;
          if ((data_idx_r + CNT_W'(1)) == scan_end_r) begin
            state_nxt = S_IDLE;
          end
        end
        if (scan_more) begin
          mem_re       = 1'b1;
          scan_ptr_nxt = scan_ptr_r + CNT_W'(1);
          data_vld_nxt = 1'b1;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      gs_r         <= osg_pkg::GS_RESET;
      gc_r         <= '0;
      data_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      gs_r         <= gs_nxt;
      gc_r         <= gc_nxt;
      data_vld_r   <= data_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    op_r          <= op_nxt;
    id_r          <= id_nxt;
    wave_r        <= wave_nxt;
    scan_ptr_r    <= scan_ptr_nxt;
    scan_end_r    <= scan_end_nxt;
    wr_ptr_r      <= wr_ptr_nxt;
    data_idx_r    <= data_idx_nxt;
    present_r     <= present_nxt;
    status_r      <= status_nxt;
    prod_r        <= prod_nxt;
    out_present_r <= out_present_nxt;
    out_id_r      <= out_id_nxt;
    out_last_r    <= out_last_nxt;
    out_none_r    <= out_none_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign busy            = state_r != S_IDLE;
  assign cfg_ready       = state_r == S_IDLE;
  assign out_strobe      = out_strobe_r;
  assign out_present     = out_present_r;
  assign out_id          = out_id_r;
  assign out_last        = out_last_r;
  assign out_none        = out_none_r;
  assign out_status      = out_status_r;
  assign out_held_count  = OCW'(count_r);
  assign out_group_count = gc_r;

`ifndef SYNTH
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("memory read and write hit the same entry");

  a_wave_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("wave result burst broken");

  a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_none |-> out_last && out_id == '0)
    else $error("empty wave result malformed");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_strobe)
    else $error("result strobe right after transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> count_r <= CNT_W'(CAPACITY))
    else $error("held count exceeds capacity");
`endif

endmodule

/* sim/osg_set_checker.sv */
`timescale 1ns / 1ps

module osg_set_checker #(
  parameter int DEPTH = osg_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [osg_pkg::OP_W-1:0]      in_op,
  input  logic [osg_pkg::ID_W-1:0]      in_ship_id,
  input  logic [osg_pkg::WAVE_W-1:0]    in_wave_index,
  input  logic                          out_strobe,
  input  logic                          out_present,
  input  logic [osg_pkg::ID_W-1:0]      out_id,
  input  logic                          out_last,
  input  logic                          out_none,
  input  logic                          out_status,
  input  logic [osg_pkg::CNT_OUT_W-1:0] out_held_count,
  input  logic [osg_pkg::CNT_OUT_W-1:0] out_group_count,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [osg_pkg::GS_W-1:0]      cfg_group_size,
  output int                            outstanding,
  output int                            bad_results,
  output int                            items_seen,
  output int                            results_seen
);

  localparam int OCW = osg_pkg::CNT_OUT_W;

  typedef struct packed {
    logic                     present;
    logic [osg_pkg::ID_W-1:0] id;
    logic                     last;
    logic                     none;
    logic                     status;
    logic [OCW-1:0]           held;
    logic [OCW-1:0]           groups;
  } set_result_t;

  // Predicted contents of the set
  logic [osg_pkg::ID_W-1:0] ids [DEPTH];
  logic                     marks [DEPTH];
  int unsigned              held_n;
  int unsigned              grp_size;

  set_result_t     pending_results [$];
  int              mismatch_n;
  int              item_n;
  int              result_n;

  function automatic int unsigned group_total();
    if (grp_size == 0 || held_n == 0) return 0;
    return (held_n + grp_size - 1) / grp_size;
  endfunction

  function automatic int find_id(input logic [osg_pkg::ID_W-1:0] id);
    for (int i = 0; i < held_n; i++)
      if (ids[i] == id) return i;
    return -1;
  endfunction

  function automatic logic append_id(input logic [osg_pkg::ID_W-1:0] id);
    if (held_n >= DEPTH) return 1'b0;
    ids[held_n]   = id;
    marks[held_n] = 1'b0;
    held_n++;
    return 1'b1;
  endfunction

  // Order-preserving removal; marks move with their entries
  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < held_n; i++) begin
      ids[i]   = ids[i + 1];
      marks[i] = marks[i + 1];
    end
    held_n--;
    marks[held_n] = 1'b0;
  endfunction

  function automatic void push_result(input logic present,
                                      input logic [osg_pkg::ID_W-1:0] id,
                                      input logic last, input logic none,
                                      input logic status);
    set_result_t r;
    r.present = present;
    r.id      = id;
    r.last    = last;
    r.none    = none;
    r.status  = status;
    r.held    = OCW'(held_n);
    r.groups  = OCW'(group_total());
    pending_results = {pending_results, r};
  endfunction

  function automatic void apply_set_op(input logic [osg_pkg::OP_W-1:0] op,
                                       input logic [osg_pkg::ID_W-1:0] id,
                                       input logic [osg_pkg::WAVE_W-1:0] wave);
    int          pos;
    int unsigned w;
    int unsigned first;
    int unsigned n;
    logic        present;
    logic        status;
    pos     = find_id(id);
    present = 1'b0;
    status  = 1'b0;
    if (op == osg_pkg::OP_WAVE) begin
      if (wave >= group_total()) begin
        push_result(1'b0, '0, 1'b1, 1'b1, 1'b0);
      end else begin
        first = wave * grp_size;
        n = held_n - first;
        if (n > grp_size) n = grp_size;
        if (n > osg_pkg::MAX_RESULTS) n = osg_pkg::MAX_RESULTS;
        for (int k = 0; k < n; k++)
          push_result(1'b0, ids[first + k], k + 1 == n, 1'b0, 1'b0);
      end
    end else begin
      case (op)
        osg_pkg::OP_QUERY: present = pos >= 0;
        osg_pkg::OP_TOGGLE: begin
          if (pos >= 0) drop_entry(pos);
          else if (append_id(id)) present = 1'b1;
          else status = 1'b1;
        end
        osg_pkg::OP_ADD: begin
          if (pos >= 0) present = 1'b1;
          else if (append_id(id)) present = 1'b1;
          else status = 1'b1;
        end
        osg_pkg::OP_REMOVE: begin
          if (pos >= 0) drop_entry(pos);
        end
        osg_pkg::OP_KEEP: begin
          if (pos >= 0) begin
            marks[pos] = 1'b1;
            present = 1'b1;
          end
        end
        osg_pkg::OP_FINISH: begin
          w = 0;
          for (int r = 0; r < held_n; r++) begin
            if (marks[r]) begin
              ids[w] = ids[r];
              w++;
            end
          end
          for (int r = 0; r < DEPTH; r++) marks[r] = 1'b0;
          held_n = w;
        end
        default: ;
      endcase
      push_result(present, '0, 1'b1, 1'b0, status);
    end
  endfunction

  always @(posedge clk) begin
    set_result_t want;
    set_result_t got;
    if (!rst_n) begin
      held_n   = 0;
      grp_size = osg_pkg::GS_RESET;
      for (int i = 0; i < DEPTH; i++) marks[i] = 1'b0;
      pending_results.delete();
      mismatch_n = 0;
      item_n     = 0;
      result_n   = 0;
    end else begin
      if (out_strobe) begin
        got.present = out_present;
        got.id      = out_id;
        got.last    = out_last;
        got.none    = out_none;
        got.status  = out_status;
        got.held    = out_held_count;
        got.groups  = out_group_count;
        result_n++;
        if (pending_results.size() == 0) begin
          mismatch_n++;
          if (mismatch_n <= 10)
            $display("unexpected result %0d: p=%0b id=%08h l=%0b n=%0b s=%0b held=%0d grp=%0d",
                     result_n, got.present, got.id, got.last, got.none, got.status,
                     got.held, got.groups);
        end else begin
          want = pending_results.pop_front();
          if (want !== got) begin
            mismatch_n++;
            if (mismatch_n <= 10) begin
              $display("result %0d mismatch", result_n);
              $display("  want p=%0b id=%08h l=%0b n=%0b s=%0b held=%0d grp=%0d",
                       want.present, want.id, want.last, want.none, want.status,
                       want.held, want.groups);
              $display("  got  p=%0b id=%08h l=%0b n=%0b s=%0b held=%0d grp=%0d",
                       got.present, got.id, got.last, got.none, got.status,
                       got.held, got.groups);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) grp_size = cfg_group_size;
      if (start && !busy) begin
        item_n++;
        apply_set_op(in_op, in_ship_id, in_wave_index);
      end
    end
    outstanding  <= pending_results.size();
    bad_results  <= mismatch_n;
    items_seen   <= item_n;
    results_seen <= result_n;
  end

endmodule

/* sim/ordered_id_set_with_groups_tb.sv */
`timescale 1ns / 1ps

module ordered_id_set_with_groups_tb;

  localparam logic [osg_pkg::OP_W-1:0] OP_SPARE = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int FILL_ADDS  = 70;
  localparam int POOL_N     = 16;
  localparam int WAVE_BITS  = osg_pkg::WAVE_W;
  localparam int GS_BITS    = osg_pkg::GS_W;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [osg_pkg::OP_W-1:0]      in_op = '0;
  logic [osg_pkg::ID_W-1:0]      in_ship_id = '0;
  logic [osg_pkg::WAVE_W-1:0]    in_wave_index = '0;
  logic                          out_strobe;
  logic                          out_present;
  logic [osg_pkg::ID_W-1:0]      out_id;
  logic                          out_last;
  logic                          out_none;
  logic                          out_status;
  logic [osg_pkg::CNT_OUT_W-1:0] out_held_count;
  logic [osg_pkg::CNT_OUT_W-1:0] out_group_count;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [osg_pkg::GS_W-1:0]      cfg_group_size = '0;

  int outstanding;
  int bad_results;
  int items_seen;
  int results_seen;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  logic [osg_pkg::ID_W-1:0] id_pool [POOL_N];

  ordered_id_set_with_groups u_dut (.*);

  osg_set_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles without any transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_cmd(input logic [osg_pkg::OP_W-1:0] op,
                          input logic [osg_pkg::ID_W-1:0] id,
                          input logic [osg_pkg::WAVE_W-1:0] wave);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_op         <= op;
    in_ship_id    <= id;
    in_wave_index <= wave;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_group_size(input logic [osg_pkg::GS_W-1:0] gs);
    if (!quiet) repeat ($urandom_range(0, 6)) @(posedge clk);
    cfg_group_size <= gs;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [osg_pkg::ID_W-1:0] pick_id();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return id_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  function automatic logic [osg_pkg::WAVE_W-1:0] pick_wave();
    if ($urandom_range(0, 3) == 0) return WAVE_BITS'($urandom_range(0, 63));
    return WAVE_BITS'($urandom_range(0, 5));
  endfunction

  task automatic random_cmds(input int count);
    int done;
    int roll;
    int keeps;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) send_cmd(osg_pkg::OP_QUERY, pick_id(), pick_wave());
      else if (roll < 27) send_cmd(osg_pkg::OP_TOGGLE, pick_id(), pick_wave());
      else if (roll < 50) send_cmd(osg_pkg::OP_ADD, pick_id(), pick_wave());
      else if (roll < 60) send_cmd(osg_pkg::OP_REMOVE, pick_id(), pick_wave());
      else if (roll < 70) begin
        // reconcile pass: a few keeps, usually closed by a finish
        keeps = $urandom_range(1, 5);
        repeat (keeps) send_cmd(osg_pkg::OP_KEEP, pick_id(), pick_wave());
        if ($urandom_range(0, 4) != 0) send_cmd(osg_pkg::OP_FINISH, $urandom(), pick_wave());
        done += keeps;
      end
      else if (roll < 73) send_cmd(osg_pkg::OP_FINISH, $urandom(), pick_wave());
      else if (roll < 96) send_cmd(osg_pkg::OP_WAVE, $urandom(), pick_wave());
      else send_cmd(OP_SPARE, $urandom(), pick_wave());
      done++;
    end
  endtask

  initial begin
    logic [osg_pkg::ID_W-1:0] base;
    for (int i = 0; i < POOL_N; i++) id_pool[i] = $urandom();
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, group size at its reset value of one
    send_cmd(osg_pkg::OP_QUERY, id_pool[0], '0);
    send_cmd(osg_pkg::OP_WAVE, '0, '0);
    send_cmd(osg_pkg::OP_ADD, id_pool[0], '0);
    send_cmd(osg_pkg::OP_ADD, id_pool[1], '1);
    send_cmd(osg_pkg::OP_ADD, id_pool[2], '0);
    send_cmd(osg_pkg::OP_ADD, id_pool[2], '0);
    send_cmd(osg_pkg::OP_QUERY, id_pool[1], '0);
    send_cmd(osg_pkg::OP_TOGGLE, id_pool[3], '0);
    send_cmd(osg_pkg::OP_TOGGLE, id_pool[0], '0);
    send_cmd(osg_pkg::OP_REMOVE, id_pool[1], '0);
    send_cmd(osg_pkg::OP_REMOVE, id_pool[5], '0);
    send_cmd(osg_pkg::OP_KEEP, id_pool[3], '0);
    send_cmd(osg_pkg::OP_KEEP, id_pool[7], '0);
    send_cmd(osg_pkg::OP_WAVE, '1, '0);
    send_cmd(osg_pkg::OP_WAVE, '0, 6'd1);
    send_cmd(osg_pkg::OP_WAVE, '0, '1);
    send_cmd(OP_SPARE, '1, '1);
    send_cmd(osg_pkg::OP_FINISH, '0, '0);
    send_cmd(osg_pkg::OP_FINISH, '0, '0);
    send_cmd(osg_pkg::OP_ADD, id_pool[4], '0);
    send_cmd(osg_pkg::OP_QUERY, id_pool[4], '0);
    drain();

    // No groups: every wave read comes back empty
    write_group_size(7'd0);
    send_cmd(osg_pkg::OP_WAVE, '0, '0);
    random_cmds(10);
    drain();

    // Groups of 64; fill the set to capacity and push past it
    write_group_size(7'd64);
    base = $urandom();
    for (int k = 0; k < FILL_ADDS; k++) send_cmd(osg_pkg::OP_ADD, base + k, '0);
    send_cmd(osg_pkg::OP_TOGGLE, base + 100, '0);
    send_cmd(osg_pkg::OP_ADD, ~base, '0);
    send_cmd(osg_pkg::OP_WAVE, '0, '0);
    send_cmd(osg_pkg::OP_WAVE, '0, 6'd1);
    send_cmd(osg_pkg::OP_TOGGLE, base + 5, '0);
    send_cmd(osg_pkg::OP_ADD, base + 200, '0);
    send_cmd(osg_pkg::OP_REMOVE, base, '0);
    send_cmd(osg_pkg::OP_KEEP, base + 10, '0);
    send_cmd(osg_pkg::OP_KEEP, base + 63, '0);
    send_cmd(osg_pkg::OP_KEEP, base + 200, '0);
    send_cmd(osg_pkg::OP_FINISH, '0, '0);
    send_cmd(osg_pkg::OP_WAVE, '0, '0);
    drain();

    write_group_size(7'd3);
    random_cmds(20);
    drain();

    write_group_size(GS_BITS'($urandom_range(1, 64)));
    random_cmds(15);
    drain();

    write_group_size(7'd2);
    random_cmds(15);
    drain();

    quiet = 1'b1;
    write_group_size(GS_BITS'($urandom_range(1, 8)));
    random_cmds(20);
    drain();
    repeat (32) @(posedge clk);

    $display("Sent %0d commands and checked %0d results over group sizes 0 to 64,",
             items_seen, results_seen);
    $display("including a set filled to capacity and refused inserts.");
    if (bad_results == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/osg_pkg.sv
hw/rtl/osg_mem.sv
hw/rtl/osg_div.sv
hw/rtl/ordered_id_set_with_groups.sv
sim/osg_set_checker.sv
sim/ordered_id_set_with_groups_tb.sv
